// ===== sv/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// Limit order book matcher package
// Shared widths, codes and book entry types for the matcher core.
// ----------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

  // Book geometry.
  localparam int BOOK_DEPTH  = 32;
  localparam int LEVEL_LIMIT = 5;
  localparam int IDX_W       = $clog2(BOOK_DEPTH);
  localparam int CNT_W       = $clog2(BOOK_DEPTH + 1);
  localparam int LVL_W       = $clog2(LEVEL_LIMIT + 1);
  localparam int ADDR_W      = IDX_W + 1;

  // Field widths.
  localparam int ID_W    = 32;
  localparam int PRICE_W = 24;
  localparam int QTY_W   = 24;
  localparam int CODE_W  = 20;
  localparam int TOT_W   = QTY_W + IDX_W + 1;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_STOCK_CODE = 1'b0;

  typedef enum logic [2:0] {
    MODE_CANCEL   = 3'd0,
    MODE_LIMIT    = 3'd1,
    MODE_CP_BEST  = 3'd2,
    MODE_OWN_BEST = 3'd3,
    MODE_FIVE_IOC = 3'd4,
    MODE_IOC      = 3'd5,
    MODE_FOK      = 3'd6,
    MODE_INVALID  = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_NO_CP     = 3'd1,
    ST_REM_CANC  = 3'd2,
    ST_FOK_REJ   = 3'd3,
    ST_INVALID   = 3'd4,
    ST_BOOK_FULL = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    KIND_TRADE  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PX_EV,
    S_SUM_RD,
    S_SUM_EV,
    S_M_RD,
    S_M_EV,
    S_POST,
    S_REST,
    S_INS_RD,
    S_INS_EV,
    S_INS_WR,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== sv/lobm_if.sv =====
// ----------------------------------------------------------------------------
// Matcher channel interfaces
// Order input channel and result output channel, valid/ready per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lobm_in_if import lobm_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    seq_id;
  logic [2:0]         mode;
  logic               side;
  logic [PRICE_W-1:0] limit_price;
  logic [QTY_W-1:0]   quantity;

  modport source (output valid, seq_id, mode, side, limit_price, quantity, input ready);
  modport sink   (input valid, seq_id, mode, side, limit_price, quantity, output ready);
endinterface

interface lobm_out_if import lobm_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [CODE_W-1:0]  instrument;
  logic [ID_W-1:0]    buy_id;
  logic [ID_W-1:0]    sell_id;
  logic [PRICE_W-1:0] trade_price;
  logic [QTY_W-1:0]   trade_quantity;
  logic [2:0]         status;
  logic [QTY_W-1:0]   cancelled_quantity;
  logic               last;

  modport source (output valid, kind, instrument, buy_id, sell_id, trade_price,
                  trade_quantity, status, cancelled_quantity, last, input ready);
  modport sink   (input valid, kind, instrument, buy_id, sell_id, trade_price,
                  trade_quantity, status, cancelled_quantity, last, output ready);
endinterface

`default_nettype wire

// ===== sv/lobm_book_ram.sv =====
// ----------------------------------------------------------------------------
// Book memory
// Both sides of the book in one array; side bit is the address MSB.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_book_ram import lobm_pkg::*; (
  input  wire logic     clk,
  input  wire mem_req_t req,
  output entry_t        rd_data
);

  entry_t mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/lobm_engine.sv =====
// ----------------------------------------------------------------------------
// Matching engine
// Sequencer that walks the book memory: match, sum, sorted insert, results.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_engine import lobm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CODE_W-1:0] stock_code,
  lobm_in_if.sink                in_ch,
  lobm_out_if.source             out_ch,
  output mem_req_t               req,
  input  wire entry_t            rd_data
);

  state_t state_r, state_nxt;

  // Order context.
  logic [ID_W-1:0]    oid_r, oid_nxt;
  mode_t              mode_r, mode_nxt;
  logic               side_r, side_nxt;
  logic [PRICE_W-1:0] px_r, px_nxt;
  logic [QTY_W-1:0]   left_r, left_nxt;
  status_t            status_r, status_nxt;
  logic [QTY_W-1:0]   canc_r, canc_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [PRICE_W-1:0] prev_r, prev_nxt;
  logic               have_prev_r, have_prev_nxt;

  // Ring pointers and fill counts per side.
  logic [IDX_W-1:0] bid_head_r, ask_head_r;
  logic [CNT_W-1:0] bid_cnt_r, ask_cnt_r;
  logic             pop_opp, push_own;

  // Output register.
  logic               ov_r;
  logic               okind_r;
  logic [CODE_W-1:0]  oinst_r;
  logic [ID_W-1:0]    obuy_r, osell_r;
  logic [PRICE_W-1:0] oprice_r;
  logic [QTY_W-1:0]   oqty_r;
  status_t            ostat_r;
  logic [QTY_W-1:0]   ocanc_r;
  logic               olast_r;
  logic               load_trade, load_stat, out_free;

  logic [IDX_W-1:0]   own_head, opp_head;
  logic [CNT_W-1:0]   own_cnt, opp_cnt;
  logic [QTY_W-1:0]   take, qrem;
  logic               newlvl, stop, shift;

  function automatic logic [ADDR_W-1:0] ring(input logic sd, input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] off);
    logic [IDX_W-1:0] pos;
    pos = head + off[IDX_W-1:0];
    return {sd, pos};
  endfunction

  assign own_head = side_r ? ask_head_r : bid_head_r;
  assign opp_head = side_r ? bid_head_r : ask_head_r;
  assign own_cnt  = side_r ? ask_cnt_r : bid_cnt_r;
  assign opp_cnt  = side_r ? bid_cnt_r : ask_cnt_r;

  assign out_free = !ov_r || out_ch.ready;
  assign take     = (left_r < rd_data.qty) ? left_r : rd_data.qty;
  assign qrem     = rd_data.qty - take;
  assign newlvl   = !have_prev_r || (rd_data.price != prev_r);

  // Whether the front opposite entry ends the match walk.
  always_comb begin
    unique case (mode_r)
      MODE_LIMIT:    stop = side_r ? (rd_data.price < px_r) : (rd_data.price > px_r);
      MODE_CP_BEST:  stop = rd_data.price != px_r;
      MODE_FIVE_IOC: stop = newlvl && (lvl_r == LVL_W'(LEVEL_LIMIT));
      default:       stop = 1'b0;
    endcase
  end

  // Insert scan moves an entry up while the new order ranks ahead of it.
  assign shift = side_r ? (rd_data.price > px_r) : (rd_data.price < px_r);

  assign in_ch.ready = (state_r == S_IDLE);

  // Next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    oid_nxt       = oid_r;
    mode_nxt      = mode_r;
    side_nxt      = side_r;
    px_nxt        = px_r;
    left_nxt      = left_r;
    status_nxt    = status_r;
    canc_nxt      = canc_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    lvl_nxt       = lvl_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    req           = '0;
    pop_opp       = 1'b0;
    push_own      = 1'b0;
    load_trade    = 1'b0;
    load_stat     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          oid_nxt       = in_ch.seq_id;
          mode_nxt      = mode_t'(in_ch.mode);
          side_nxt      = in_ch.side;
          px_nxt        = in_ch.limit_price;
          left_nxt      = in_ch.quantity;
          status_nxt    = ST_DONE;
          canc_nxt      = '0;
          lvl_nxt       = '0;
          have_prev_nxt = 1'b0;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (mode_r)
          MODE_CANCEL: state_nxt = S_FINAL;
          MODE_INVALID: begin
            status_nxt = ST_INVALID;
            canc_nxt   = left_r;
            state_nxt  = S_FINAL;
          end
          MODE_LIMIT, MODE_FIVE_IOC, MODE_IOC: state_nxt = S_M_RD;
          MODE_CP_BEST: begin
            if (opp_cnt == '0) begin
              status_nxt = ST_NO_CP;
              canc_nxt   = left_r;
              state_nxt  = S_FINAL;
            end else begin
              req.rd_en   = 1'b1;
              req.rd_addr = ring(!side_r, opp_head, '0);
              state_nxt   = S_PX_EV;
            end
          end
          MODE_OWN_BEST: begin
            if (own_cnt == '0) begin
              status_nxt = ST_NO_CP;
              canc_nxt   = left_r;
              state_nxt  = S_FINAL;
            end else if (left_r == '0) begin
              state_nxt = S_FINAL;
            end else begin
              req.rd_en   = 1'b1;
              req.rd_addr = ring(side_r, own_head, '0);
              state_nxt   = S_PX_EV;
            end
          end
          MODE_FOK: begin
            idx_nxt   = '0;
            total_nxt = '0;
            state_nxt = S_SUM_RD;
          end
        endcase
      end
      // Best price of the book just read sets the working price.
      S_PX_EV: begin
        px_nxt    = rd_data.price;
        state_nxt = (mode_r == MODE_CP_BEST) ? S_M_RD : S_REST;
      end
      S_SUM_RD: begin
        if (idx_r == opp_cnt) begin
          if (TOT_W'(left_r) > total_r) begin
            status_nxt = ST_FOK_REJ;
            canc_nxt   = left_r;
            state_nxt  = S_FINAL;
          end else begin
            state_nxt = S_M_RD;
          end
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = ring(!side_r, opp_head, idx_r);
          state_nxt   = S_SUM_EV;
        end
      end
      S_SUM_EV: begin
        total_nxt = total_r + TOT_W'(rd_data.qty);
        idx_nxt   = idx_r + CNT_W'(1);
        state_nxt = S_SUM_RD;
      end
      S_M_RD: begin
        if ((left_r == '0) || (opp_cnt == '0)) begin
          state_nxt = S_POST;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = ring(!side_r, opp_head, '0);
          state_nxt   = S_M_EV;
        end
      end
      // End the walk on a stop, else trade against the front entry once the result slot is free.
      S_M_EV: begin
        if (stop) begin
          state_nxt = S_POST;
        end else if (out_free) begin
          load_trade = 1'b1;
          left_nxt   = left_r - take;
          if (qrem == '0) begin
            pop_opp = 1'b1;
          end else begin
            req.wr_en       = 1'b1;
            req.wr_addr     = ring(!side_r, opp_head, '0);
            req.wr_data     = rd_data;
            req.wr_data.qty = qrem;
          end
          if (newlvl && (mode_r == MODE_FIVE_IOC)) begin
            lvl_nxt       = lvl_r + LVL_W'(1);
            prev_nxt      = rd_data.price;
            have_prev_nxt = 1'b1;
          end
          state_nxt = S_M_RD;
        end
      end
      S_POST: begin
        priority case (mode_r)
          MODE_LIMIT, MODE_CP_BEST: state_nxt = (left_r != '0) ? S_REST : S_FINAL;
          MODE_FIVE_IOC, MODE_IOC: begin
            if (left_r != '0) begin
              status_nxt = ST_REM_CANC;
              canc_nxt   = left_r;
            end
            state_nxt = S_FINAL;
          end
          default: state_nxt = S_FINAL;
        endcase
      end
      S_REST: begin
        if (own_cnt >= CNT_W'(BOOK_DEPTH)) begin
          status_nxt = ST_BOOK_FULL;
          canc_nxt   = left_r;
          state_nxt  = S_FINAL;
        end else if (own_cnt == '0) begin
          idx_nxt   = '0;
          state_nxt = S_INS_WR;
        end else begin
          idx_nxt   = own_cnt - CNT_W'(1);
          state_nxt = S_INS_RD;
        end
      end
      S_INS_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = ring(side_r, own_head, idx_r);
        state_nxt   = S_INS_EV;
      end
      // Scan from the tail, moving lower-ranked entries up one place.
      S_INS_EV: begin
        if (shift) begin
          req.wr_en   = 1'b1;
          req.wr_addr = ring(side_r, own_head, idx_r + CNT_W'(1));
          req.wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_INS_WR;
          end else begin
            idx_nxt   = idx_r - CNT_W'(1);
            state_nxt = S_INS_RD;
          end
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        req.wr_en         = 1'b1;
        req.wr_addr       = ring(side_r, own_head, idx_r);
        req.wr_data.id    = oid_r;
        req.wr_data.price = px_r;
        req.wr_data.qty   = left_r;
        push_own          = 1'b1;
        state_nxt         = S_FINAL;
      end
      S_FINAL: begin
        if (out_free) begin
          load_stat = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      bid_head_r <= '0;
      ask_head_r <= '0;
      bid_cnt_r  <= '0;
      ask_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (pop_opp) begin
        if (side_r) begin
          bid_head_r <= bid_head_r + IDX_W'(1);
          bid_cnt_r  <= bid_cnt_r - CNT_W'(1);
        end else begin
          ask_head_r <= ask_head_r + IDX_W'(1);
          ask_cnt_r  <= ask_cnt_r - CNT_W'(1);
        end
      end
      if (push_own) begin
        if (side_r) begin
          ask_cnt_r <= ask_cnt_r + CNT_W'(1);
        end else begin
          bid_cnt_r <= bid_cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Order context registers.
  always_ff @(posedge clk) begin
    oid_r       <= oid_nxt;
    mode_r      <= mode_nxt;
    side_r      <= side_nxt;
    px_r        <= px_nxt;
    left_r      <= left_nxt;
    status_r    <= status_nxt;
    canc_r      <= canc_nxt;
    idx_r       <= idx_nxt;
    total_r     <= total_nxt;
    lvl_r       <= lvl_nxt;
    prev_r      <= prev_nxt;
    have_prev_r <= have_prev_nxt;
  end

  // Output register: one pending result transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load_trade || load_stat) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_trade) begin
      okind_r  <= KIND_TRADE;
      oinst_r  <= stock_code;
      obuy_r   <= side_r ? rd_data.id : oid_r;
      osell_r  <= side_r ? oid_r : rd_data.id;
      oprice_r <= rd_data.price;
      oqty_r   <= take;
      ostat_r  <= ST_DONE;
      ocanc_r  <= '0;
      olast_r  <= 1'b0;
    end else if (load_stat) begin
      okind_r  <= KIND_STATUS;
      oinst_r  <= stock_code;
      obuy_r   <= '0;
      osell_r  <= '0;
      oprice_r <= '0;
      oqty_r   <= '0;
      ostat_r  <= status_r;
      ocanc_r  <= canc_r;
      olast_r  <= 1'b1;
    end
  end

  assign out_ch.valid              = ov_r;
  assign out_ch.kind               = okind_r;
  assign out_ch.instrument         = oinst_r;
  assign out_ch.buy_id             = obuy_r;
  assign out_ch.sell_id            = osell_r;
  assign out_ch.trade_price        = oprice_r;
  assign out_ch.trade_quantity     = oqty_r;
  assign out_ch.status             = ostat_r;
  assign out_ch.cancelled_quantity = ocanc_r;
  assign out_ch.last               = olast_r;

  // Checks.
  a_bid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    bid_cnt_r <= CNT_W'(BOOK_DEPTH)) else $error("bid count over depth");
  a_ask_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ask_cnt_r <= CNT_W'(BOOK_DEPTH)) else $error("ask count over depth");
  a_trade_qty: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (okind_r == KIND_TRADE)) |-> (oqty_r != '0)) else $error("empty trade");
  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (okind_r == olast_r)) else $error("last flag not on status item");
  a_left_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M_EV) |=> (left_r <= $past(left_r))) else $error("remainder grew");

endmodule

`default_nettype wire

// ===== sv/limit_order_book_matcher_core.sv =====
// ----------------------------------------------------------------------------
// Limit order book matcher core
// Single-instrument price-time priority matching with an APB register port.
// ----------------------------------------------------------------------------
// One order is handled at a time. Both books sit in a single memory with one
// read and one write port and a registered read. Every order passes an accept
// step, a dispatch step and a step loading its status item; a cancelled or
// invalid order or an empty-book reject needs nothing more.
// Modes that walk the opposite book read, then evaluate the front entry for
// each trade, and then end the walk and post the outcome. The best-price
// modes first fetch the best price, fill-or-kill first sums the opposite
// entries and compares the total with the order quantity, and resting a
// remainder runs an insert scan from the tail, which moves each
// lower-ranked entry up one place. A stalled result register holds the
// sequencer until the result can be taken. Results leave through a
// one-entry output register, and the order input is ready whenever the
// sequencer is idle. Each side holds up to 32 resting orders; the memory
// needs no clearing after reset.
`default_nettype none

module limit_order_book_matcher_core import lobm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lobm_in_if.sink                    in_ch,
  lobm_out_if.source                 out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [CODE_W-1:0] stock_code_r;
  mem_req_t          req;
  entry_t            rd_data;
  logic              reg_sel;

  assign reg_sel    = cfg_paddr[2];
  assign cfg_pready = 1'b1;

  // Register write on the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stock_code_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (reg_sel == REG_STOCK_CODE)) begin
      stock_code_r <= cfg_pwdata[CODE_W-1:0];
    end
  end

  // Read back.
  always_comb begin
    cfg_prdata = '0;
    if (reg_sel == REG_STOCK_CODE) begin
      cfg_prdata = CFG_DATA_W'(stock_code_r);
    end
  end

  lobm_book_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  lobm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .stock_code (stock_code_r),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .req        (req),
    .rd_data    (rd_data)
  );

endmodule

`default_nettype wire
